@@ design/swdk_pkg.sv @@
`default_nettype none

package swdk_pkg;

    // Run mode codes as seen on run_mode
    typedef enum logic [1:0] {
        MODE_STOP    = 2'd0,
        MODE_FORWARD = 2'd1,
        MODE_REVERSE = 2'd2
    } mode_t;

    // Confirmed key events for one tick
    typedef struct packed {
        logic faster;
        logic slower;
        logic forward;
        logic reverse;
        logic stop;
    } key_hits_t;

    // One result beat
    typedef struct packed {
        logic [3:0] coil;
        logic [7:0] segment_n;
        logic [3:0] speed;
        mode_t      mode;
    } result_t;

    localparam int CONFIRM_W = 7;
    localparam int SPEED_W   = 4;
    localparam int PHASE_W   = 2;

    // Configuration register indexes
    localparam logic REG_SPEED_CONFIRM = 1'b0;
    localparam logic REG_DIR_CONFIRM   = 1'b1;

    localparam logic [CONFIRM_W-1:0] SPEED_CONFIRM_RESET = 7'd80;
    localparam logic [CONFIRM_W-1:0] DIR_CONFIRM_RESET   = 7'd20;

    localparam logic [SPEED_W-1:0] SPEED_MIN = 4'd2;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 4'd9;

    localparam logic [3:0] FWD_PATTERN [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
    localparam logic [3:0] REV_PATTERN [4] = '{4'h8, 4'h4, 4'h2, 4'h1};

    // Seven-segment codes, active high, digits 0 to F
    localparam logic [7:0] SEG_CODE [16] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
        8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
    };

endpackage

`default_nettype wire

@@ design/swdk_key_filter.sv @@
`default_nettype none

module swdk_key_filter
    import swdk_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic [4:0]           keys_n,
    input  wire logic [CONFIRM_W-1:0] speed_confirm,
    input  wire logic [CONFIRM_W-1:0] dir_confirm,
    output key_hits_t                 hits
);

    logic [CONFIRM_W-1:0] count_reg  [5];
    logic [CONFIRM_W-1:0] count_next [5];
    logic [4:0]           hit;
    logic [CONFIRM_W-1:0] limit_speed;
    logic [CONFIRM_W-1:0] limit_dir;

    // Treat a zero confirm value as one
    assign limit_speed = (speed_confirm == '0) ? CONFIRM_W'(1) : speed_confirm;
    assign limit_dir   = (dir_confirm == '0) ? CONFIRM_W'(1) : dir_confirm;

    // Count low ticks, fire and restart at the limit, clear when released
    always_comb
    begin
        logic [CONFIRM_W:0]   inc;
        logic [CONFIRM_W-1:0] limit;
        for (int k = 0; k < 5; k++)
        begin
            limit = (k < 2) ? limit_speed : limit_dir;
            inc   = {1'b0, count_reg[k]} + (CONFIRM_W+1)'(1);
            if (keys_n[k])
            begin
                hit[k]        = 1'b0;
                count_next[k] = '0;
            end
            else if (inc >= {1'b0, limit})
            begin
                hit[k]        = 1'b1;
                count_next[k] = '0;
            end
            else
            begin
                hit[k]        = 1'b0;
                count_next[k] = inc[CONFIRM_W-1:0];
            end
        end
    end

    assign hits.faster  = hit[0];
    assign hits.slower  = hit[1];
    assign hits.forward = hit[2];
    assign hits.reverse = hit[3];
    assign hits.stop    = hit[4];

    // Advance counters on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 5; k++)
                count_reg[k] <= '0;
        end
        else if (advance)
        begin
            for (int k = 0; k < 5; k++)
                count_reg[k] <= count_next[k];
        end
    end

endmodule

`default_nettype wire

@@ design/swdk_drive.sv @@
`default_nettype none

module swdk_drive
    import swdk_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire key_hits_t hits,
    output result_t        result
);

    mode_t              mode_reg,  mode_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [3:0]         timer_reg, timer_next;

    always_comb
    begin
        logic [SPEED_W-1:0] spd;
        mode_t              md;
        logic [PHASE_W-1:0] ph;
        logic [3:0]         tm;
        logic [3:0]         tm_inc;
        logic [3:0]         coil;

        // Apply speed keys, faster first, wrapping at both ends
        spd = speed_reg;
        if (hits.faster)
            spd = (spd >= SPEED_MAX) ? SPEED_MIN : spd + SPEED_W'(1);
        if (hits.slower)
            spd = (spd <= SPEED_MIN) ? SPEED_MAX : spd - SPEED_W'(1);

        // Stop over reverse over forward
        md = mode_reg;
        if (hits.forward)
            md = MODE_FORWARD;
        if (hits.reverse)
            md = MODE_REVERSE;
        if (hits.stop)
            md = MODE_STOP;

        // Restart the phase on a mode change
        ph = phase_reg;
        tm = timer_reg;
        if (md != mode_reg)
        begin
            ph = '0;
            tm = '0;
        end

        // Show the current phase, then advance the timer
        coil = 4'h0;
        case (md)
            MODE_FORWARD, MODE_REVERSE:
            begin
                coil   = (md == MODE_FORWARD) ? FWD_PATTERN[ph] : REV_PATTERN[ph];
                tm_inc = tm + 4'd1;
                if (tm_inc >= spd)
                begin
                    tm = '0;
                    ph = ph + PHASE_W'(1);
                end
                else
                begin
                    tm = tm_inc;
                end
            end
            default:
            begin
                tm_inc = '0;
                ph     = '0;
                tm     = '0;
            end
        endcase

        mode_next  = md;
        speed_next = spd;
        phase_next = ph;
        timer_next = tm;

        result.coil      = coil;
        result.segment_n = ~SEG_CODE[spd];
        result.speed     = spd;
        result.mode      = md;
    end

    // Hold state between beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_STOP;
            speed_reg <= SPEED_MIN;
            phase_reg <= '0;
            timer_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            speed_reg <= speed_next;
            phase_reg <= phase_next;
            timer_reg <= timer_next;
        end
    end

endmodule

`default_nettype wire

@@ design/stepper_wave_drive_with_keys.sv @@
// Channel | Handshake            | Beat carries
// --------+----------------------+------------------------------------------------
// in      | in_valid / in_ready  | key_faster_n key_slower_n key_forward_n
//         |                      | key_reverse_n key_stop_n
// out     | out_valid / out_ready| coil_drive segment_drive_n speed_value run_mode
// config  | wr_en                | wr_index wr_data, no stall
//
// One beat per cycle while the output is not stalled: key counters, drive state
// and the output register all load at the edge that accepts a beat, so its
// result can be taken next cycle. in_ready is high while the output register is
// empty or being drained, so a stalled output holds its beat and blocks the next
// input only until taken. Reset clears counters, mode, phase and speed (2), and
// loads confirm values 80 and 20.
`default_nettype none

module stepper_wave_drive_with_keys
    import swdk_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 key_faster_n,
    input  wire logic                 key_slower_n,
    input  wire logic                 key_forward_n,
    input  wire logic                 key_reverse_n,
    input  wire logic                 key_stop_n,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [3:0]                coil_drive,
    output logic [7:0]                segment_drive_n,
    output logic [3:0]                speed_value,
    output logic [1:0]                run_mode,
    input  wire logic                 wr_en,
    input  wire logic                 wr_index,
    input  wire logic [CONFIRM_W-1:0] wr_data
);

    logic [CONFIRM_W-1:0] speed_confirm_reg;
    logic [CONFIRM_W-1:0] dir_confirm_reg;
    logic                 accept;
    key_hits_t            hits;
    result_t              result;
    result_t              result_reg;
    logic                 out_valid_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_confirm_reg <= SPEED_CONFIRM_RESET;
            dir_confirm_reg   <= DIR_CONFIRM_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SPEED_CONFIRM: speed_confirm_reg <= wr_data;
                REG_DIR_CONFIRM:   dir_confirm_reg   <= wr_data;
                default:           ;
            endcase
        end
    end

    swdk_key_filter u_keys (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (accept),
        .keys_n        ({key_stop_n, key_reverse_n, key_forward_n,
                         key_slower_n, key_faster_n}),
        .speed_confirm (speed_confirm_reg),
        .dir_confirm   (dir_confirm_reg),
        .hits          (hits)
    );

    swdk_drive u_drive (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .hits    (hits),
        .result  (result)
    );

    // Output register: load on accept, drop valid when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result;
    end

    assign out_valid       = out_valid_reg;
    assign coil_drive      = result_reg.coil;
    assign segment_drive_n = result_reg.segment_n;
    assign speed_value     = result_reg.speed;
    assign run_mode        = result_reg.mode;

    // An accepted beat always shows up at the output next cycle
    a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted beat did not reach output");

    // Stopped means coils off
    a_stop_coils: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && run_mode == MODE_STOP) |-> coil_drive == 4'h0)
        else $error("coils driven while stopped");

    // Running means exactly one coil
    a_run_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && run_mode != MODE_STOP) |-> $onehot(coil_drive))
        else $error("coil pattern not one-hot while running");

    // Speed stays in range and matches the display
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (speed_value >= SPEED_MIN && speed_value <= SPEED_MAX
                       && segment_drive_n == ~SEG_CODE[speed_value]))
        else $error("speed out of range or display mismatch");

endmodule

`default_nettype wire
